[sv/dctn_pkg.sv]
// ----------------------------------------------------------------------------
// dctn_pkg
// Shared widths, payload types and index tables of the dipole coupling tensor.
// ----------------------------------------------------------------------------
package dctn_pkg;

  localparam int POS_W   = 32;              // Q15.16 position
  localparam int DIF_W   = POS_W + 1;       // displacement
  localparam int MAG_W   = 24;              // |d| below the far limit
  localparam int SQR_W   = 2 * MAG_W;       // one squared component
  localparam int SUM_W   = SQR_W + 2;       // sum of three squares
  localparam int RAD_W   = 64;              // radicand, sum shifted by 14
  localparam int RT_W    = RAD_W / 2;       // root R
  localparam int UN_W    = 62;              // numerator of the unit vector
  localparam int UQ_W    = 32;              // quotient width of the unit vector
  localparam int UA_W    = 31;              // unit vector magnitude, Q1.30
  localparam int PRD_W   = 2 * UA_W;        // Ua * Ub
  localparam int G_W     = 66;              // signed G
  localparam int GM_W    = 64;              // |G|
  localparam int DEN_W   = 96;              // R^3
  localparam int ENT_W   = 48;              // Q31.16 entry
  localparam int N_ENT   = 6;

  localparam logic [ENT_W-1:0] ENT_POS_LIM = {1'b0, {(ENT_W-1){1'b1}}};
  localparam logic [ENT_W-1:0] ENT_NEG_LIM = {1'b1, {(ENT_W-1){1'b0}}};

  // row and column of each unique entry: xx, yy, zz, xy, xz, yz
  localparam int PAIR_A [N_ENT] = '{0, 1, 2, 0, 0, 1};
  localparam int PAIR_B [N_ENT] = '{0, 1, 2, 1, 2, 2};

  typedef struct packed {
    logic signed [POS_W-1:0] first_x;
    logic signed [POS_W-1:0] first_y;
    logic signed [POS_W-1:0] first_z;
    logic signed [POS_W-1:0] second_x;
    logic signed [POS_W-1:0] second_y;
    logic signed [POS_W-1:0] second_z;
  } dctn_in_t;

  typedef struct packed {
    logic signed [ENT_W-1:0] entry_xx;
    logic signed [ENT_W-1:0] entry_yy;
    logic signed [ENT_W-1:0] entry_zz;
    logic signed [ENT_W-1:0] entry_xy;
    logic signed [ENT_W-1:0] entry_xz;
    logic signed [ENT_W-1:0] entry_yz;
    logic                    coincident;
    logic                    saturated;
  } dctn_out_t;

endpackage

[sv/dctn_pos_if.sv]
// ----------------------------------------------------------------------------
// dctn_pos_if
// Valid/ready channel carrying one pair of positions.
// ----------------------------------------------------------------------------
interface dctn_pos_if;
  import dctn_pkg::*;

  logic     valid;
  logic     ready;
  dctn_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/dctn_ten_if.sv]
// ----------------------------------------------------------------------------
// dctn_ten_if
// Valid/ready channel carrying one tensor result.
// ----------------------------------------------------------------------------
interface dctn_ten_if;
  import dctn_pkg::*;

  logic      valid;
  logic      ready;
  dctn_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/dipole_coupling_tensor.sv]
// Throughput: one position pair per cycle; the pipeline stalls as a whole
// while a finished result waits on the output.
// Depth is set by the 32-stage root and the 32- and 48-stage dividers.
// Reset clears the valid bits of all stages; data registers are not reset.
// ----------------------------------------------------------------------------
// dipole_coupling_tensor
// Dipole coupling tensor (3 u u^T - I) / r^3 of two points, six entries.
// ----------------------------------------------------------------------------
module dipole_coupling_tensor (
  input logic     clk,
  input logic     rst,
  dctn_pos_if.sink   pos,
  dctn_ten_if.source tensor
);
  import dctn_pkg::*;

  localparam int ST_SUM  = 3;
  localparam int ST_ROOT = ST_SUM + RT_W;
  localparam int ST_UNUM = ST_ROOT + 1;
  localparam int ST_PART = ST_UNUM + 1;
  localparam int ST_DEN  = ST_PART + 1;
  localparam int ST_UA   = ST_UNUM + UQ_W;
  localparam int ST_PROD = ST_UA + 1;
  localparam int ST_G    = ST_PROD + 1;
  localparam int ST_GM   = ST_G + 1;
  localparam int ST_NUM  = ST_GM + 1;
  localparam int ST_Q    = ST_NUM + ENT_W;
  localparam int ST_OUT  = ST_Q + 1;

  logic en;
  logic v [1:ST_OUT];

  assign en        = !v[ST_OUT] || tensor.ready;
  assign pos.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= ST_OUT; i++) v[i] <= 1'b0;
    end else if (en) begin
      v[1] <= pos.valid;
      for (int i = 2; i <= ST_OUT; i++) v[i] <= v[i-1];
    end
  end

  // stage 1: displacement, magnitude, special cases
  logic [POS_W-1:0]               fa [3];
  logic [POS_W-1:0]               sb [3];
  logic [DIF_W-1:0]               dd [3];
  logic [DIF_W-1:0]               dm [3];
  logic [2:0][MAG_W-1:0]          mag_line [1:ST_ROOT];
  logic [2:0]                     sgn_line [1:ST_UA];
  logic [1:0]                     flag_line [1:ST_Q];  // {coincident, far}
  logic                           coin_c, far_c;
  logic [2:0][MAG_W-1:0]          mag_c;
  logic [2:0]                     sgn_c;

  assign fa[0] = pos.data.first_x;
  assign fa[1] = pos.data.first_y;
  assign fa[2] = pos.data.first_z;
  assign sb[0] = pos.data.second_x;
  assign sb[1] = pos.data.second_y;
  assign sb[2] = pos.data.second_z;

  always_comb begin
    coin_c = 1'b1;
    far_c  = 1'b0;
    for (int k = 0; k < 3; k++) begin
      dd[k]    = {fa[k][POS_W-1], fa[k]} - {sb[k][POS_W-1], sb[k]};
      dm[k]    = dd[k][DIF_W-1] ? -dd[k] : dd[k];
      sgn_c[k] = dd[k][DIF_W-1];
      mag_c[k] = dm[k][MAG_W-1:0];
      if (dd[k] != '0) coin_c = 1'b0;
      if (dm[k][DIF_W-1:MAG_W] != '0) far_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_line[1]  <= mag_c;
      sgn_line[1]  <= sgn_c;
      flag_line[1] <= {coin_c, far_c};
      for (int i = 2; i <= ST_ROOT; i++) mag_line[i] <= mag_line[i-1];
      for (int i = 2; i <= ST_UA; i++) sgn_line[i] <= sgn_line[i-1];
      for (int i = 2; i <= ST_Q; i++) flag_line[i] <= flag_line[i-1];
    end
  end

  // stages 2 and 3: squared length, scaled by 2^14
  logic [SQR_W-1:0] sq_q [3];
  logic [RAD_W-1:0] rad_q;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) sq_q[k] <= mag_line[1][k] * mag_line[1][k];
      rad_q <= {SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]),
                (RAD_W - SUM_W)'(0)};
    end
  end

  logic [RT_W-1:0] root;

  dctn_sqrt #(.XW(RAD_W)) u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (rad_q),
    .root     (root)
  );

  // unit vector numerators, R^2 and R^3
  logic [UN_W-1:0]   unum_q [3];
  logic [RT_W-1:0]   r_q;
  logic [2*RT_W-1:0] r2_q;
  logic [2*RT_W-1:0] part_lo_q, part_hi_q;
  logic [DEN_W-1:0]  den_line [ST_DEN:ST_NUM];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        unum_q[k] <= {1'b0, mag_line[ST_ROOT][k], 37'd0} + UN_W'(root[RT_W-1:1]);
      end
      r_q       <= root;
      r2_q      <= root * root;
      part_lo_q <= r2_q[RT_W-1:0] * r_q;
      part_hi_q <= r2_q[2*RT_W-1:RT_W] * r_q;
      den_line[ST_DEN] <= DEN_W'(part_lo_q) + {part_hi_q, (DEN_W - 2*RT_W)'(0)};
      for (int i = ST_DEN + 1; i <= ST_NUM; i++) den_line[i] <= den_line[i-1];
    end
  end

  logic [UQ_W-1:0] ua [3];

  for (genvar k = 0; k < 3; k++) begin : g_unit
    dctn_div #(.NW(UN_W), .DW(RT_W), .QW(UQ_W)) u_div (
      .clk (clk),
      .en  (en),
      .num (unum_q[k]),
      .den (r_q),
      .quo (ua[k])
    );
  end

  // products, G, |G| and the rounded numerator
  logic [PRD_W-1:0] prd_q [N_ENT];
  logic [N_ENT-1:0] pneg_q;
  logic [N_ENT-1:0] pneg_c;
  logic [N_ENT-1:0] gneg_c;
  logic [N_ENT-1:0] over_c;
  logic [G_W-1:0]   g_q   [N_ENT];
  logic [GM_W-1:0]  gm_q  [N_ENT];
  logic [DEN_W-1:0] num_q [N_ENT];
  logic [N_ENT-1:0] neg_line  [ST_GM:ST_Q];
  logic [N_ENT-1:0] over_line [ST_NUM+1:ST_Q];
  logic [ENT_W-1:0] q_ent [N_ENT];

  for (genvar j = 0; j < N_ENT; j++) begin : g_ent
    logic [GM_W-1:0] t3;
    logic [G_W-1:0]  gpos;
    logic [G_W-1:0]  gsg;
    logic [G_W-1:0]  gabs;

    assign t3   = {1'b0, prd_q[j], 1'b0} + {2'b00, prd_q[j]};
    assign gpos = pneg_q[j] ? -{2'b00, t3} : {2'b00, t3};
    assign gsg  = (PAIR_A[j] == PAIR_B[j]) ? gpos - (G_W'(1) << 60) : gpos;
    assign gabs = g_q[j][G_W-1] ? -g_q[j] : g_q[j];

    assign pneg_c[j] = sgn_line[ST_UA][PAIR_A[j]] ^ sgn_line[ST_UA][PAIR_B[j]];
    assign gneg_c[j] = g_q[j][G_W-1];
    // quotient would need more than the entry width
    assign over_c[j] = (DEN_W'(num_q[j][DEN_W-1:ENT_W]) >= den_line[ST_NUM]);

    always_ff @(posedge clk) begin
      if (en) begin
        prd_q[j]       <= ua[PAIR_A[j]][UA_W-1:0] * ua[PAIR_B[j]][UA_W-1:0];
        g_q[j]         <= gsg;
        gm_q[j]        <= gabs[GM_W-1:0];
        num_q[j]       <= {7'd0, gm_q[j], 25'd0} + {1'b0, den_line[ST_GM][DEN_W-1:1]};
      end
    end

    dctn_div #(.NW(DEN_W), .DW(DEN_W), .QW(ENT_W)) u_div (
      .clk (clk),
      .en  (en),
      .num (num_q[j]),
      .den (den_line[ST_NUM]),
      .quo (q_ent[j])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pneg_q                <= pneg_c;
      neg_line[ST_GM]       <= gneg_c;
      over_line[ST_NUM+1]   <= over_c;
      for (int i = ST_GM + 1; i <= ST_Q; i++) neg_line[i] <= neg_line[i-1];
      for (int i = ST_NUM + 2; i <= ST_Q; i++) over_line[i] <= over_line[i-1];
    end
  end

  // output stage: clip, apply sign, force zero for the special cases
  logic [ENT_W-1:0] ent_c [N_ENT];
  logic [N_ENT-1:0] sat_c;
  dctn_out_t        out_next, out_q;
  logic             zero_c;

  assign zero_c = flag_line[ST_Q][1] || flag_line[ST_Q][0];

  always_comb begin
    logic [ENT_W-1:0] lim;
    logic [ENT_W-1:0] val;
    for (int j = 0; j < N_ENT; j++) begin
      lim      = neg_line[ST_Q][j] ? ENT_NEG_LIM : ENT_POS_LIM;
      sat_c[j] = over_line[ST_Q][j] || (q_ent[j] > lim);
      val      = sat_c[j] ? lim : q_ent[j];
      ent_c[j] = zero_c ? '0 : (neg_line[ST_Q][j] ? -val : val);
    end
    out_next.entry_xx   = ent_c[0];
    out_next.entry_yy   = ent_c[1];
    out_next.entry_zz   = ent_c[2];
    out_next.entry_xy   = ent_c[3];
    out_next.entry_xz   = ent_c[4];
    out_next.entry_yz   = ent_c[5];
    out_next.coincident = flag_line[ST_Q][1];
    out_next.saturated  = !zero_c && (sat_c != '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_q <= out_next;
    end
  end

  assign tensor.valid = v[ST_OUT];
  assign tensor.data  = out_q;

  a_coin_zero: assert property (@(posedge clk) disable iff (rst)
    tensor.valid && tensor.data.coincident |->
      tensor.data.entry_xx == '0 && tensor.data.entry_yy == '0 &&
      tensor.data.entry_zz == '0 && tensor.data.entry_xy == '0 &&
      tensor.data.entry_xz == '0 && tensor.data.entry_yz == '0 &&
      !tensor.data.saturated)
    else $error("coincident result carries nonzero entries");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    tensor.valid && tensor.data.saturated |->
      tensor.data.entry_xx == ENT_POS_LIM || tensor.data.entry_xx == ENT_NEG_LIM ||
      tensor.data.entry_yy == ENT_POS_LIM || tensor.data.entry_yy == ENT_NEG_LIM ||
      tensor.data.entry_zz == ENT_POS_LIM || tensor.data.entry_zz == ENT_NEG_LIM ||
      tensor.data.entry_xy == ENT_POS_LIM || tensor.data.entry_xy == ENT_NEG_LIM ||
      tensor.data.entry_xz == ENT_POS_LIM || tensor.data.entry_xz == ENT_NEG_LIM ||
      tensor.data.entry_yz == ENT_POS_LIM || tensor.data.entry_yz == ENT_NEG_LIM)
    else $error("saturated flag without a clipped entry");

  a_reset_empty: assert property (@(posedge clk) !rst && $past(rst) |-> !tensor.valid)
    else $error("result valid right after reset");

endmodule

[sv/dctn_sqrt.sv]
// ----------------------------------------------------------------------------
// dctn_sqrt
// Pipelined integer square root, one result bit per stage, floor rounding.
// ----------------------------------------------------------------------------
module dctn_sqrt #(
  parameter int XW = dctn_pkg::RAD_W
) (
  input  logic            clk,
  input  logic            en,
  input  logic [XW-1:0]   radicand,
  output logic [XW/2-1:0] root
);
  import dctn_pkg::*;

  localparam int HW = XW / 2;

  logic [HW:0]   rem_q  [HW-1];
  logic [XW-1:0] x_q    [HW-1];
  logic [HW-1:0] root_q [HW];

  for (genvar i = 0; i < HW; i++) begin : g_step
    logic [HW:0]   rem_in;
    logic [XW-1:0] x_in;
    logic [HW-1:0] root_in;
    logic [HW+2:0] t;
    logic [HW+2:0] trial;
    logic          take;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign x_in    = radicand;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign x_in    = x_q[i-1];
      assign root_in = root_q[i-1];
    end

    assign t     = {rem_in, x_in[XW-1:XW-2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign take  = (t >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[i] <= {root_in[HW-2:0], take};
      end
    end

    if (i < HW - 1) begin : g_carry
      logic [HW+2:0] diff;
      assign diff = t - trial;
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i] <= take ? diff[HW:0] : t[HW:0];
          x_q[i]   <= {x_in[XW-3:0], 2'b00};
        end
      end
    end
  end

  assign root = root_q[HW-1];
endmodule

[sv/dctn_div.sv]
// ----------------------------------------------------------------------------
// dctn_div
// Pipelined restoring divider, one quotient bit per stage.
// The upper part of the numerator above the quotient bits must be below den.
// ----------------------------------------------------------------------------
module dctn_div #(
  parameter int NW = dctn_pkg::UN_W,
  parameter int DW = dctn_pkg::RT_W,
  parameter int QW = dctn_pkg::UQ_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);
  import dctn_pkg::*;

  logic [DW-1:0] rem_q [QW-1];
  logic [QW-1:0] lo_q  [QW-1];
  logic [DW-1:0] den_q [QW-1];
  logic [QW-1:0] quo_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [QW-1:0] lo_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   t;
    logic          take;

    if (i == 0) begin : g_first
      assign rem_in = DW'(num[NW-1:QW]);
      assign lo_in  = num[QW-1:0];
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign lo_in  = lo_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    assign t    = {rem_in, lo_in[QW-1]};
    assign take = (t >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        quo_q[i] <= {quo_in[QW-2:0], take};
      end
    end

    if (i < QW - 1) begin : g_carry
      logic [DW:0] diff;
      assign diff = t - {1'b0, den_in};
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i] <= take ? diff[DW-1:0] : t[DW-1:0];
          lo_q[i]  <= {lo_in[QW-2:0], 1'b0};
          den_q[i] <= den_in;
        end
      end
    end
  end

  assign quo = quo_q[QW-1];
endmodule
